>>> rtl/stack_machine_executor_defines.svh
// Assertion macros for the executor's checks of its own logic.
`ifndef STACK_MACHINE_EXECUTOR_DEFINES_SVH
`define STACK_MACHINE_EXECUTOR_DEFINES_SVH

// Checked only while out of reset.
`define SME_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define SME_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/sme_pkg.sv
package sme_pkg;

    // Field widths
    localparam int DATA_W  = 64;
    localparam int CMD_W   = 3;
    localparam int CAUSE_W = 3;
    localparam int DEPTH_W = 5;

    // Default stack depth
    localparam int STACK_DEPTH_DEF = 16;

    // Opcodes
    localparam logic [CMD_W-1:0] OP_PUSH  = 3'd0;
    localparam logic [CMD_W-1:0] OP_PRINT = 3'd1;
    localparam logic [CMD_W-1:0] OP_READ  = 3'd2;
    localparam logic [CMD_W-1:0] OP_ADD   = 3'd3;
    localparam logic [CMD_W-1:0] OP_STOP  = 3'd4;

    // Halt causes
    localparam logic [CAUSE_W-1:0] CAUSE_RUN       = 3'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_STOP      = 3'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_BADOP     = 3'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_OVERFLOW  = 3'd3;
    localparam logic [CAUSE_W-1:0] CAUSE_UNDERFLOW = 3'd4;

    // Per-cell shift command
    typedef logic [1:0] cell_op_t;
    localparam cell_op_t CELL_HOLD = 2'd0;
    localparam cell_op_t CELL_DOWN = 2'd1;  // take entry from the cell above (push)
    localparam cell_op_t CELL_UP   = 2'd2;  // take entry from the cell below (pop)

endpackage

>>> rtl/sme_cell.sv
// One stack entry. Cell 0 is the top of stack.
module sme_cell (
    input  logic                      aclk,
    input  sme_pkg::cell_op_t         op,
    input  logic [sme_pkg::DATA_W-1:0] prev_data,
    input  logic [sme_pkg::DATA_W-1:0] next_data,
    output logic [sme_pkg::DATA_W-1:0] data
);

    logic [sme_pkg::DATA_W-1:0] data_reg;
    logic [sme_pkg::DATA_W-1:0] data_next;

    // Shift select
    always_comb begin
        unique case (op)
            sme_pkg::CELL_DOWN: data_next = prev_data;
            sme_pkg::CELL_UP:   data_next = next_data;
            default:            data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

>>> rtl/stack_machine_executor.sv
// Stack-machine executor: runs one instruction per item on a stack of STACK_DEPTH 64-bit
// entries and returns one result item per input item. The stack is a row of entry
// cells that shift together, so an item is accepted every clock while s_ready is high.
// Results come from an output register loaded at acceptance; s_ready drops only while
// that register holds an item and m_ready is low. After a halt the stack no longer
// changes until reset; every item still returns a result.
module stack_machine_executor #(
    parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input items
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [sme_pkg::CMD_W-1:0]         s_command,
    input  logic signed [sme_pkg::DATA_W-1:0] s_push_value,
    input  logic                              s_read_ok,
    input  logic signed [sme_pkg::DATA_W-1:0] s_read_value,
    // result items
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_print_valid,
    output logic signed [sme_pkg::DATA_W-1:0] m_print_value,
    output logic                              m_halted,
    output logic [sme_pkg::CAUSE_W-1:0]       m_halt_cause,
    output logic [sme_pkg::DEPTH_W-1:0]       m_depth_now
);

    `include "stack_machine_executor_defines.svh"

    localparam int CW = $clog2(STACK_DEPTH + 1);

    // Machine state
    logic [CW-1:0]                count_reg, count_next;
    logic                         halt_reg, halt_next;
    logic [sme_pkg::CAUSE_W-1:0]  reason_reg, reason_next;

    // Cell row
    logic [sme_pkg::DATA_W-1:0]   cell_data [STACK_DEPTH];
    sme_pkg::cell_op_t            cell_op [STACK_DEPTH];
    sme_pkg::cell_op_t            shift_op;
    logic                         add_sel;
    logic [sme_pkg::DATA_W-1:0]   top_in;
    logic [sme_pkg::DATA_W-1:0]   sum;

    // Result
    logic                         pvalid;
    logic [sme_pkg::DATA_W-1:0]   pval;
    logic [31:0]                  count_ext;

    // Output register
    logic                         m_valid_reg;
    logic                         print_valid_reg;
    logic [sme_pkg::DATA_W-1:0]   print_value_reg;
    logic                         halted_reg;
    logic [sme_pkg::CAUSE_W-1:0]  cause_reg;
    logic [sme_pkg::DEPTH_W-1:0]  depth_reg;

    logic accept;
    logic full;
    logic empty;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == CW'(STACK_DEPTH));
    assign empty   = (count_reg == '0);
    assign sum     = cell_data[0] + cell_data[1];

    // Instruction decode
    always_comb begin
        count_next  = count_reg;
        halt_next   = halt_reg;
        reason_next = reason_reg;
        shift_op    = sme_pkg::CELL_HOLD;
        add_sel     = 1'b0;
        top_in      = s_push_value;
        pvalid      = 1'b0;
        pval        = '0;
        if (accept && !halt_reg) begin
            unique case (s_command)
                sme_pkg::OP_PUSH: begin
                    if (full) begin
                        halt_next   = 1'b1;
                        reason_next = sme_pkg::CAUSE_OVERFLOW;
                    end else begin
                        shift_op   = sme_pkg::CELL_DOWN;
                        count_next = count_reg + 1'b1;
                    end
                end
                sme_pkg::OP_PRINT: begin
                    if (empty) begin
                        halt_next   = 1'b1;
                        reason_next = sme_pkg::CAUSE_UNDERFLOW;
                    end else begin
                        pvalid     = 1'b1;
                        pval       = cell_data[0];
                        shift_op   = sme_pkg::CELL_UP;
                        count_next = count_reg - 1'b1;
                    end
                end
                sme_pkg::OP_READ: begin
                    top_in = s_read_value;
                    if (s_read_ok) begin
                        if (full) begin
                            halt_next   = 1'b1;
                            reason_next = sme_pkg::CAUSE_OVERFLOW;
                        end else begin
                            shift_op   = sme_pkg::CELL_DOWN;
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
                sme_pkg::OP_ADD: begin
                    // two pops and a push: the row moves up, the top takes the sum
                    if (count_reg >= CW'(2)) begin
                        shift_op   = sme_pkg::CELL_UP;
                        add_sel    = 1'b1;
                        top_in     = sum;
                        count_next = count_reg - 1'b1;
                    end else begin
                        count_next = '0;
                    end
                end
                sme_pkg::OP_STOP: begin
                    halt_next   = 1'b1;
                    reason_next = sme_pkg::CAUSE_STOP;
                end
                default: begin
                    halt_next   = 1'b1;
                    reason_next = sme_pkg::CAUSE_BADOP;
                end
            endcase
        end
    end

    // Per-cell commands
    always_comb begin
        for (int i = 0; i < STACK_DEPTH; i++) begin
            cell_op[i] = shift_op;
        end
        if (add_sel) begin
            cell_op[0] = sme_pkg::CELL_DOWN;
        end
    end

    // Row of cells
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        logic [sme_pkg::DATA_W-1:0] prev_d;
        logic [sme_pkg::DATA_W-1:0] next_d;
        if (i == 0) begin : g_top
            assign prev_d = top_in;
        end else begin : g_mid
            assign prev_d = cell_data[i-1];
        end
        if (i == STACK_DEPTH - 1) begin : g_bot
            assign next_d = '0;
        end else begin : g_up
            assign next_d = cell_data[i+1];
        end
        sme_cell u_cell (
            .aclk      (aclk),
            .op        (cell_op[i]),
            .prev_data (prev_d),
            .next_data (next_d),
            .data      (cell_data[i])
        );
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            halt_reg   <= 1'b0;
            reason_reg <= sme_pkg::CAUSE_RUN;
        end else begin
            count_reg  <= count_next;
            halt_reg   <= halt_next;
            reason_reg <= reason_next;
        end
    end

    assign count_ext = 32'(count_next);

    // Output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            print_valid_reg <= pvalid;
            print_value_reg <= pval;
            halted_reg      <= halt_next;
            cause_reg       <= halt_next ? reason_next : sme_pkg::CAUSE_RUN;
            depth_reg       <= count_ext[sme_pkg::DEPTH_W-1:0];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_print_valid = print_valid_reg;
    assign m_print_value = print_value_reg;
    assign m_halted      = halted_reg;
    assign m_halt_cause  = cause_reg;
    assign m_depth_now   = depth_reg;

    // Checks
    `SME_ASSERT(a_halt_sticky, halt_reg |=> halt_reg, "halt flag cleared without reset")
    `SME_ASSERT(a_count_bound, count_reg <= CW'(STACK_DEPTH), "stack count above depth")
    `SME_ASSERT(a_halted_frozen, (accept && halt_reg) |=> $stable(count_reg), "stack moved while halted")
    `SME_ASSERT(a_print_running, (m_valid && m_print_valid) |-> !m_halted, "print result reported as halted")

endmodule

>>> test/tb_stack_machine_executor.sv
module tb_stack_machine_executor;
    timeunit 1ns;
    timeprecision 1ps;

    import sme_pkg::*;

    localparam int               STACK_SLOTS = STACK_DEPTH_DEF;
    localparam logic [DATA_W-1:0] WORD_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [DATA_W-1:0] WORD_MIN   = 64'h8000_0000_0000_0000;
    localparam logic [DATA_W-1:0] WORD_ONES  = '1;
    localparam int               MAX_PRINTED = 30;

    // How the machine is finally brought to a halt
    typedef enum {
        HALT_PUSH_FULL,
        HALT_READ_FULL,
        HALT_UNDERFLOW,
        HALT_STOP,
        HALT_BADOP
    } halt_case_e;

    // One result item as seen on the m_ side
    typedef struct {
        logic              pv;
        logic [DATA_W-1:0] pval;
        logic              halted;
        logic [CAUSE_W-1:0] cause;
        logic [DEPTH_W-1:0] depth;
    } exec_result_t;

    // Tracks the machine state and the results still owed by the block
    class exec_scoreboard;
        logic [DATA_W-1:0]  stack_mem [STACK_SLOTS];
        int                 depth;
        bit                 halted;
        logic [CAUSE_W-1:0] cause;
        exec_result_t       pending_results[$];
        int                 errors;
        int                 checked;
        int                 printed;
        int                 max_depth;

        function new();
            depth     = 0;
            halted    = 1'b0;
            cause     = CAUSE_RUN;
            errors    = 0;
            checked   = 0;
            printed   = 0;
            max_depth = 0;
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        function void enter_halt(logic [CAUSE_W-1:0] why);
            halted = 1'b1;
            cause  = why;
        endfunction

        function void push_word(logic [DATA_W-1:0] w);
            if (depth >= STACK_SLOTS) begin
                enter_halt(CAUSE_OVERFLOW);
            end else begin
                stack_mem[depth] = w;
                depth++;
            end
        endfunction

        // Execute one accepted instruction and queue the result it produces
        function void note_instruction(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] push_val,
                                       logic rok, logic [DATA_W-1:0] read_val);
            exec_result_t r;
            logic [DATA_W-1:0] lhs;
            logic [DATA_W-1:0] rhs;
            r.pv   = 1'b0;
            r.pval = '0;
            if (!halted) begin
                case (cmd)
                    OP_PUSH: push_word(push_val);
                    OP_PRINT: begin
                        if (depth > 0) begin
                            depth--;
                            r.pv   = 1'b1;
                            r.pval = stack_mem[depth];
                            printed++;
                        end else begin
                            enter_halt(CAUSE_UNDERFLOW);
                        end
                    end
                    OP_READ: if (rok) push_word(read_val);
                    OP_ADD: begin
                        // short stack: whatever is there is dropped, no halt
                        if (depth >= 2) begin
                            rhs = stack_mem[depth-1];
                            lhs = stack_mem[depth-2];
                            depth -= 2;
                            push_word(lhs + rhs);
                        end else begin
                            depth = 0;
                        end
                    end
                    OP_STOP: enter_halt(CAUSE_STOP);
                    default: enter_halt(CAUSE_BADOP);
                endcase
            end
            if (depth > max_depth) max_depth = depth;
            r.halted = halted;
            r.cause  = halted ? cause : CAUSE_RUN;
            r.depth  = DEPTH_W'(depth);
            pending_results.push_back(r);
        endfunction

        // Compare one result item against the oldest expectation
        task check_result(exec_result_t got);
            exec_result_t want;
            if (pending_results.size() == 0) begin
                report_mismatch("result item with no instruction outstanding");
                return;
            end
            want = pending_results.pop_front();
            if (got.pv !== want.pv)
                report_mismatch($sformatf("result %0d print_valid got %b want %b",
                                          checked, got.pv, want.pv));
            if (got.pval !== want.pval)
                report_mismatch($sformatf("result %0d print_value got %h want %h",
                                          checked, got.pval, want.pval));
            if (got.halted !== want.halted)
                report_mismatch($sformatf("result %0d halted got %b want %b",
                                          checked, got.halted, want.halted));
            if (got.cause !== want.cause)
                report_mismatch($sformatf("result %0d halt_cause got %0d want %0d",
                                          checked, got.cause, want.cause));
            if (got.depth !== want.depth)
                report_mismatch($sformatf("result %0d depth_now got %0d want %0d",
                                          checked, got.depth, want.depth));
            checked++;
        endtask
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic [CMD_W-1:0]          s_command;
    logic signed [DATA_W-1:0]  s_push_value;
    logic                      s_read_ok;
    logic signed [DATA_W-1:0]  s_read_value;
    logic                      m_valid;
    logic                      m_ready;
    logic                      m_print_valid;
    logic signed [DATA_W-1:0]  m_print_value;
    logic                      m_halted;
    logic [CAUSE_W-1:0]        m_halt_cause;
    logic [DEPTH_W-1:0]        m_depth_now;

    exec_scoreboard sb = new();
    bit             idle_gaps = 1'b1;
    int             n_sent    = 0;
    halt_case_e     halt_case;

    stack_machine_executor u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_push_value  (s_push_value),
        .s_read_ok     (s_read_ok),
        .s_read_value  (s_read_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_print_valid (m_print_valid),
        .m_print_value (m_print_value),
        .m_halted      (m_halted),
        .m_halt_cause  (m_halt_cause),
        .m_depth_now   (m_depth_now)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_gaps || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // Random word with extra weight on the corners
    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return WORD_ONES;
            3: return '0;
            4: return DATA_W'($urandom_range(0, 100));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Present one instruction, starting at a falling edge, until it is taken
    task automatic send_instr(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] pv,
                              input logic rok, input logic [DATA_W-1:0] rv);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_command    = cmd;
        s_push_value = pv;
        s_read_ok    = rok;
        s_read_value = rv;
        s_valid      = 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_instruction(cmd, pv, rok, rv);
        n_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_drain();
        while (sb.pending_results.size() != 0) @(negedge aclk);
    endtask

    // Well-formed random program that never halts; switches at random between fill and drain phases
    task automatic run_random(input int n);
        logic [CMD_W-1:0] cmd;
        logic             rok;
        int               r;
        int               push_lim;
        int               read_lim;
        int               print_lim;
        push_lim  = 40;
        read_lim  = 62;
        print_lim = 88;
        for (int i = 0; i < n; i++) begin
            if (i % 60 == 0) begin
                idle_gaps = ($urandom_range(0, 4) != 0);
                if ($urandom_range(0, 1) != 0) begin
                    push_lim = 40; read_lim = 62; print_lim = 88;
                end else begin
                    push_lim = 15; read_lim = 30; print_lim = 80;
                end
            end
            r = $urandom_range(0, 99);
            if (r < push_lim)       cmd = OP_PUSH;
            else if (r < read_lim)  cmd = OP_READ;
            else if (r < print_lim) cmd = OP_PRINT;
            else                    cmd = OP_ADD;
            rok = 1'($urandom_range(0, 1));
            if (cmd == OP_READ && sb.depth < STACK_SLOTS) rok = ($urandom_range(0, 3) != 0);
            // keep clear of the halting cases
            if (sb.depth >= STACK_SLOTS && cmd == OP_PUSH) cmd = OP_PRINT;
            if (sb.depth >= STACK_SLOTS && cmd == OP_READ) rok = 1'b0;
            if (sb.depth == 0 && cmd == OP_PRINT) cmd = OP_PUSH;
            send_instr(cmd, rand_word(), rok, rand_word());
        end
    endtask

    // Bring the machine to its single halt, by a cause picked at random
    task automatic run_halt_case();
        halt_case = halt_case_e'($urandom_range(0, 4));
        case (halt_case)
            HALT_PUSH_FULL, HALT_READ_FULL: begin
                while (sb.depth < STACK_SLOTS) send_instr(OP_PUSH, rand_word(), 1'b0, rand_word());
                if (halt_case == HALT_PUSH_FULL)
                    send_instr(OP_PUSH, rand_word(), 1'b0, rand_word());
                else
                    send_instr(OP_READ, rand_word(), 1'b1, rand_word());
            end
            HALT_UNDERFLOW: begin
                while (sb.depth > 0) send_instr(OP_PRINT, rand_word(), 1'b0, rand_word());
                send_instr(OP_PRINT, rand_word(), 1'b1, rand_word());
            end
            HALT_STOP: send_instr(OP_STOP, rand_word(), 1'b0, rand_word());
            default:   send_instr(CMD_W'(OP_STOP + 1 + $urandom_range(0, 2)), rand_word(),
                                  1'b1, rand_word());
        endcase
    endtask

    // Result side: random back-pressure, with stall-free stretches
    initial begin
        int n;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            n = gap_len();
            if (n > 0) begin
                m_ready = 1'b0;
                repeat (n) @(negedge aclk);
            end
            m_ready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        exec_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.pv     = m_print_valid;
            got.pval   = m_print_value;
            got.halted = m_halted;
            got.cause  = m_halt_cause;
            got.depth  = m_depth_now;
            sb.check_result(got);
        end
    end

    // Watchdog
    initial begin
        #1_000_000;
        $display("tb_stack_machine_executor failed");
        $finish;
    end

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_command    = OP_PUSH;
        s_push_value = '0;
        s_read_ok    = 1'b0;
        s_read_value = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: short-stack add, invalid read, wrapping sums, field extremes
        send_instr(OP_ADD,   '0,        1'b0, '0);
        send_instr(OP_READ,  WORD_ONES, 1'b0, WORD_MAX);
        send_instr(OP_PUSH,  WORD_MAX,  1'b0, WORD_ONES);
        send_instr(OP_ADD,   '0,        1'b1, '0);
        send_instr(OP_PUSH,  WORD_MAX,  1'b0, '0);
        send_instr(OP_PUSH,  WORD_MAX,  1'b0, '0);
        send_instr(OP_ADD,   '0,        1'b0, '0);
        send_instr(OP_PRINT, '0,        1'b0, '0);
        send_instr(OP_PUSH,  WORD_MIN,  1'b0, '0);
        send_instr(OP_PUSH,  WORD_MIN,  1'b0, '0);
        send_instr(OP_ADD,   '0,        1'b0, '0);
        send_instr(OP_PRINT, WORD_ONES, 1'b1, WORD_ONES);
        send_instr(OP_READ,  '0,        1'b1, WORD_MIN);
        send_instr(OP_READ,  '0,        1'b1, WORD_MAX);
        send_instr(OP_ADD,   '0,        1'b0, '0);
        send_instr(OP_PRINT, '0,        1'b0, '0);
        send_instr(OP_PUSH,  WORD_ONES, 1'b0, '0);
        send_instr(OP_READ,  WORD_ONES, 1'b1, 64'd1);
        send_instr(OP_ADD,   '0,        1'b0, '0);
        send_instr(OP_PRINT, '0,        1'b0, '0);
        send_instr(OP_READ,  WORD_ONES, 1'b0, WORD_ONES);

        // sender holds off until the block has caught up
        s_valid = 1'b0;
        wait_drain();

        run_random(950);
        s_valid = 1'b0;
        wait_drain();
        run_random(950);

        run_halt_case();
        // after the halt every opcode must leave the state alone
        for (int i = 0; i < 30; i++)
            send_instr(CMD_W'($urandom_range(0, 7)), rand_word(), 1'($urandom_range(0, 1)),
                       rand_word());
        s_valid = 1'b0;

        wait_drain();
        repeat (10) @(negedge aclk);
        if (sb.pending_results.size() != 0)
            sb.report_mismatch("expected results still outstanding at end of run");

        $display("Ran %0d instructions, checked %0d results, %0d values printed, deepest stack %0d.",
                 n_sent, sb.checked, sb.printed, sb.max_depth);
        $display("Final halt via %s with cause %0d, followed by instructions while halted.",
                 halt_case.name(), sb.cause);
        if (sb.errors == 0)
            $display("tb_stack_machine_executor passed");
        else
            $display("tb_stack_machine_executor failed");
        $finish;
    end

endmodule
